@@ rtl/core/rar_pkg.sv @@
// ----------------------------------------------------------------------------
// rar_pkg
// Shared widths, fixed-point constants, types and helpers for the
// axis rotation pipeline.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int COORD_W  = 32;
    localparam int AXIS_W   = 32;
    localparam int THETA_W  = 31;
    localparam int SC_STEPS = 24;

    // angle / sine / cosine datapath, Q.30
    localparam int ANG_W  = 34;
    localparam int CS_W   = 34;
    localparam int TERM_W = 32;
    localparam int PROD_W = 68;
    localparam int RND_W  = 38;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CS_W-1:0]  GAIN_Q30    = 34'sd652032874;
    localparam logic signed [CS_W-1:0]  ONE_Q30     = 34'sd1073741824;
    localparam logic signed [PROD_W-1:0] HALF_LSB   = 68'sd536870912;

    localparam logic signed [TERM_W-1:0] TERM_MAX = {1'b0, {(TERM_W-1){1'b1}}};
    localparam logic signed [TERM_W-1:0] TERM_MIN = {1'b1, {(TERM_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] vz;
        logic signed [AXIS_W-1:0]  ax;
        logic signed [AXIS_W-1:0]  ay;
        logic signed [AXIS_W-1:0]  az;
    } t_geom;

    typedef struct packed {
        logic signed [TERM_W-1:0] m00;
        logic signed [TERM_W-1:0] m01;
        logic signed [TERM_W-1:0] m02;
        logic signed [TERM_W-1:0] m10;
        logic signed [TERM_W-1:0] m11;
        logic signed [TERM_W-1:0] m12;
        logic signed [TERM_W-1:0] m20;
        logic signed [TERM_W-1:0] m21;
        logic signed [TERM_W-1:0] m22;
    } t_mat;

    // arctan(2^-i) in Q.30, rounded
    function automatic logic signed [ANG_W-1:0] f_atan(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            24: v = 34'sd64;
            25: v = 34'sd32;
            26: v = 34'sd16;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            30: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q.30 product rounded half up
    function automatic logic signed [RND_W-1:0] f_rnd30(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = (p + HALF_LSB) >>> 30;
        return t[RND_W-1:0];
    endfunction

    function automatic logic signed [TERM_W-1:0] f_clamp(input logic signed [RND_W-1:0] v);
        logic signed [TERM_W-1:0] r;
        if (v > RND_W'(TERM_MAX)) begin
            r = TERM_MAX;
        end else if (v < RND_W'(TERM_MIN)) begin
            r = TERM_MIN;
        end else begin
            r = v[TERM_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/rar_in_if.sv @@
// ----------------------------------------------------------------------------
// rar_in_if
// Input channel: point, axis and angle beat with valid/ready.
// ----------------------------------------------------------------------------
interface rar_in_if;
    import rar_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vec_x;
    logic signed [COORD_W-1:0] vec_y;
    logic signed [COORD_W-1:0] vec_z;
    logic signed [AXIS_W-1:0]  axis_x;
    logic signed [AXIS_W-1:0]  axis_y;
    logic signed [AXIS_W-1:0]  axis_z;
    logic signed [THETA_W-1:0] theta;

    modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, theta,
                    input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, theta,
                    output ready);
endinterface

@@ rtl/core/rar_out_if.sv @@
// ----------------------------------------------------------------------------
// rar_out_if
// Output channel: rotated point beat with saturation flag.
// ----------------------------------------------------------------------------
interface rar_out_if;
    import rar_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] rot_x;
    logic signed [COORD_W-1:0] rot_y;
    logic signed [COORD_W-1:0] rot_z;
    logic                      saturated;

    modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

@@ rtl/core/rar_cordic.sv @@
// ----------------------------------------------------------------------------
// rar_cordic
// Quadrant fold followed by one pipelined CORDIC rotation step per stage.
// Geometry rides alongside. Outputs are unflipped x/y plus the flip flag.
// ----------------------------------------------------------------------------
module rar_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [rar_pkg::THETA_W-1:0] i_theta,
    input  rar_pkg::t_geom                    i_geom,
    output logic                              o_vld,
    output logic signed [rar_pkg::CS_W-1:0]   o_x,
    output logic signed [rar_pkg::CS_W-1:0]   o_y,
    output logic                              o_flip,
    output rar_pkg::t_geom                    o_geom
);
    import rar_pkg::*;

    logic signed [CS_W-1:0]  r_x    [0:SC_STEPS];
    logic signed [CS_W-1:0]  r_y    [0:SC_STEPS];
    logic signed [ANG_W-1:0] r_z    [0:SC_STEPS];
    logic                    r_flip [0:SC_STEPS];
    t_geom                   r_geom [0:SC_STEPS];
    logic [SC_STEPS:0]       r_vld;

    logic signed [ANG_W-1:0] n_z0;
    logic                    n_flip0;
    logic signed [ANG_W-1:0] z4;

    // theta Q3.28 -> Q.30, fold into +-pi/2
    always_comb begin
        z4 = {{(ANG_W-THETA_W-2){i_theta[THETA_W-1]}}, i_theta, 2'b00};
        if (z4 > HALF_PI_Q30) begin
            n_z0    = z4 - PI_Q30;
            n_flip0 = 1'b1;
        end else if (z4 < -HALF_PI_Q30) begin
            n_z0    = z4 + PI_Q30;
            n_flip0 = 1'b1;
        end else begin
            n_z0    = z4;
            n_flip0 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= n_z0;
            r_flip[0] <= n_flip0;
            r_geom[0] <= i_geom;
        end
    end

    for (genvar gi = 0; gi < SC_STEPS; gi++) begin : g_step
        logic signed [CS_W-1:0]  n_x;
        logic signed [CS_W-1:0]  n_y;
        logic signed [ANG_W-1:0] n_z;

        always_comb begin
            if (r_z[gi] >= 0) begin
                n_x = r_x[gi] - (r_y[gi] >>> gi);
                n_y = r_y[gi] + (r_x[gi] >>> gi);
                n_z = r_z[gi] - f_atan(gi);
            end else begin
                n_x = r_x[gi] + (r_y[gi] >>> gi);
                n_y = r_y[gi] - (r_x[gi] >>> gi);
                n_z = r_z[gi] + f_atan(gi);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[gi+1] <= r_vld[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[gi+1]    <= n_x;
                r_y[gi+1]    <= n_y;
                r_z[gi+1]    <= n_z;
                r_flip[gi+1] <= r_flip[gi];
                r_geom[gi+1] <= r_geom[gi];
            end
        end
    end

    assign o_vld  = r_vld[SC_STEPS];
    assign o_x    = r_x[SC_STEPS];
    assign o_y    = r_y[SC_STEPS];
    assign o_flip = r_flip[SC_STEPS];
    assign o_geom = r_geom[SC_STEPS];

endmodule

@@ rtl/core/rar_matrix.sv @@
// ----------------------------------------------------------------------------
// rar_matrix
// Builds the nine Rodrigues terms from sine, cosine and axis in four stages:
// sign fix and k, k*a and s*a, kx*a, add and clamp.
// ----------------------------------------------------------------------------
module rar_matrix (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic signed [rar_pkg::CS_W-1:0] i_x,
    input  logic signed [rar_pkg::CS_W-1:0] i_y,
    input  logic                            i_flip,
    input  rar_pkg::t_geom                  i_geom,
    output logic                            o_vld,
    output rar_pkg::t_mat                   o_mat,
    output rar_pkg::t_geom                  o_geom
);
    import rar_pkg::*;

    logic [3:0] r_vld;

    // stage 1
    logic signed [CS_W-1:0] r_s1, r_c1, r_k1;
    t_geom                  r_g1;
    // stage 2
    logic signed [RND_W-1:0] r_kx [0:2];
    logic signed [RND_W-1:0] r_sa [0:2];
    logic signed [CS_W-1:0]  r_c2;
    t_geom                   r_g2;
    // stage 3
    logic signed [RND_W-1:0] r_p00, r_p11, r_p22, r_p01, r_p02, r_p12;
    logic signed [RND_W-1:0] r_sa3 [0:2];
    logic signed [CS_W-1:0]  r_c3;
    t_geom                   r_g3;
    // stage 4
    t_mat                    r_mat;
    t_geom                   r_g4;

    logic signed [CS_W-1:0]   n_s, n_c;
    logic signed [AXIS_W-1:0] a1 [0:2];
    logic signed [AXIS_W-1:0] a2 [0:2];
    logic signed [TERM_W-1:0] kxc [0:2];
    logic signed [RND_W-1:0]  c3e;

    always_comb begin
        n_c = i_flip ? -i_x : i_x;
        n_s = i_flip ? -i_y : i_y;
    end

    assign a1[0] = r_g1.ax;
    assign a1[1] = r_g1.ay;
    assign a1[2] = r_g1.az;
    assign a2[0] = r_g2.ax;
    assign a2[1] = r_g2.ay;
    assign a2[2] = r_g2.az;

    for (genvar gj = 0; gj < 3; gj++) begin : g_kx
        assign kxc[gj] = f_clamp(r_kx[gj]);
    end

    assign c3e = RND_W'(r_c3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s;
            r_c1 <= n_c;
            r_k1 <= ONE_Q30 - n_c;
            r_g1 <= i_geom;

            for (int j = 0; j < 3; j++) begin
                r_kx[j] <= f_rnd30(PROD_W'(r_k1) * PROD_W'(a1[j]));
                r_sa[j] <= f_rnd30(PROD_W'(r_s1) * PROD_W'(a1[j]));
            end
            r_c2 <= r_c1;
            r_g2 <= r_g1;

            r_p00 <= f_rnd30(PROD_W'(kxc[0]) * PROD_W'(a2[0]));
            r_p11 <= f_rnd30(PROD_W'(kxc[1]) * PROD_W'(a2[1]));
            r_p22 <= f_rnd30(PROD_W'(kxc[2]) * PROD_W'(a2[2]));
            r_p01 <= f_rnd30(PROD_W'(kxc[0]) * PROD_W'(a2[1]));
            r_p02 <= f_rnd30(PROD_W'(kxc[0]) * PROD_W'(a2[2]));
            r_p12 <= f_rnd30(PROD_W'(kxc[1]) * PROD_W'(a2[2]));
            for (int j = 0; j < 3; j++) begin
                r_sa3[j] <= r_sa[j];
            end
            r_c3 <= r_c2;
            r_g3 <= r_g2;

            r_mat.m00 <= f_clamp(c3e + r_p00);
            r_mat.m11 <= f_clamp(c3e + r_p11);
            r_mat.m22 <= f_clamp(c3e + r_p22);
            r_mat.m01 <= f_clamp(r_p01 - r_sa3[2]);
            r_mat.m10 <= f_clamp(r_p01 + r_sa3[2]);
            r_mat.m02 <= f_clamp(r_p02 + r_sa3[1]);
            r_mat.m20 <= f_clamp(r_p02 - r_sa3[1]);
            r_mat.m12 <= f_clamp(r_p12 - r_sa3[0]);
            r_mat.m21 <= f_clamp(r_p12 + r_sa3[0]);
            r_g4 <= r_g3;
        end
    end

    assign o_vld  = r_vld[3];
    assign o_mat  = r_mat;
    assign o_geom = r_g4;

endmodule

@@ rtl/core/rar_apply.sv @@
// ----------------------------------------------------------------------------
// rar_apply
// Multiplies the point by the matrix (nine rounded products), then sums each
// row and saturates into the output register.
// ----------------------------------------------------------------------------
module rar_apply (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  rar_pkg::t_mat                      i_mat,
    input  rar_pkg::t_geom                     i_geom,
    output logic                               o_vld,
    output logic signed [rar_pkg::COORD_W-1:0] o_rot_x,
    output logic signed [rar_pkg::COORD_W-1:0] o_rot_y,
    output logic signed [rar_pkg::COORD_W-1:0] o_rot_z,
    output logic                               o_sat
);
    import rar_pkg::*;

    localparam int MP_W  = COORD_W + TERM_W;
    localparam int PT_W  = COORD_W + 2;
    localparam int SUM_W = COORD_W + 4;
    localparam logic signed [MP_W-1:0]  M_HALF = MP_W'(64'sd536870912);
    localparam logic signed [SUM_W-1:0] C_MAX  = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] C_MIN  = -C_MAX - SUM_W'(1);

    logic [1:0] r_vld;
    logic signed [PT_W-1:0]    r_pt [0:8];
    logic signed [COORD_W-1:0] r_rot [0:2];
    logic                      r_sat;

    logic signed [COORD_W-1:0] vin [0:2];
    logic signed [TERM_W-1:0]  mt  [0:8];
    logic signed [PT_W-1:0]    n_pt [0:8];
    logic signed [SUM_W-1:0]   row [0:2];
    logic signed [COORD_W-1:0] n_rot [0:2];
    logic [2:0]                clip;

    assign vin[0] = i_geom.vx;
    assign vin[1] = i_geom.vy;
    assign vin[2] = i_geom.vz;
    assign mt[0] = i_mat.m00;
    assign mt[1] = i_mat.m01;
    assign mt[2] = i_mat.m02;
    assign mt[3] = i_mat.m10;
    assign mt[4] = i_mat.m11;
    assign mt[5] = i_mat.m12;
    assign mt[6] = i_mat.m20;
    assign mt[7] = i_mat.m21;
    assign mt[8] = i_mat.m22;

    for (genvar gp = 0; gp < 9; gp++) begin : g_prod
        logic signed [MP_W-1:0] prod;
        logic signed [MP_W-1:0] shr;
        assign prod = MP_W'(vin[gp % 3]) * MP_W'(mt[gp]);
        assign shr  = (prod + M_HALF) >>> 30;
        assign n_pt[gp] = shr[PT_W-1:0];
    end

    for (genvar gr = 0; gr < 3; gr++) begin : g_row
        always_comb begin
            row[gr] = SUM_W'(r_pt[3*gr]) + SUM_W'(r_pt[3*gr+1]) + SUM_W'(r_pt[3*gr+2]);
            if (row[gr] > C_MAX) begin
                n_rot[gr] = C_MAX[COORD_W-1:0];
                clip[gr]  = 1'b1;
            end else if (row[gr] < C_MIN) begin
                n_rot[gr] = C_MIN[COORD_W-1:0];
                clip[gr]  = 1'b1;
            end else begin
                n_rot[gr] = row[gr][COORD_W-1:0];
                clip[gr]  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int p = 0; p < 9; p++) begin
                r_pt[p] <= n_pt[p];
            end
            for (int r = 0; r < 3; r++) begin
                r_rot[r] <= n_rot[r];
            end
            r_sat <= |clip;
        end
    end

    assign o_vld   = r_vld[1];
    assign o_rot_x = r_rot[0];
    assign o_rot_y = r_rot[1];
    assign o_rot_z = r_rot[2];
    assign o_sat   = r_sat;

endmodule

@@ rtl/core/vector_rotate_about_axis.sv @@
// ----------------------------------------------------------------------------
// vector_rotate_about_axis
// Rodrigues rotation of a Q16.16 point about a Q2.30 unit axis.
// ----------------------------------------------------------------------------
// Accepts one beat per clock unless backpressure stalls it, and returns one
// rotated point per beat, in order. It has one fold stage, one CORDIC step
// per stage, four matrix-building stages and two point-multiply stages.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so backpressure stalls every stage in place.
// ----------------------------------------------------------------------------
module vector_rotate_about_axis (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rar_in_if.sink     i_in,
    rar_out_if.source  o_out
);
    import rar_pkg::*;

    logic                   en;
    logic                   cor_vld;
    logic signed [CS_W-1:0] cor_x, cor_y;
    logic                   cor_flip;
    t_geom                  cor_geom;
    t_geom                  in_geom;
    logic                   mat_vld;
    t_mat                   mat;
    t_geom                  mat_geom;

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    assign in_geom.vx = i_in.vec_x;
    assign in_geom.vy = i_in.vec_y;
    assign in_geom.vz = i_in.vec_z;
    assign in_geom.ax = i_in.axis_x;
    assign in_geom.ay = i_in.axis_y;
    assign in_geom.az = i_in.axis_z;

    rar_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in.valid),
        .i_theta (i_in.theta),
        .i_geom  (in_geom),
        .o_vld   (cor_vld),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_flip  (cor_flip),
        .o_geom  (cor_geom)
    );

    rar_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (cor_vld),
        .i_x     (cor_x),
        .i_y     (cor_y),
        .i_flip  (cor_flip),
        .i_geom  (cor_geom),
        .o_vld   (mat_vld),
        .o_mat   (mat),
        .o_geom  (mat_geom)
    );

    rar_apply u_apply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (mat_vld),
        .i_mat   (mat),
        .i_geom  (mat_geom),
        .o_vld   (o_out.valid),
        .o_rot_x (o_out.rot_x),
        .o_rot_y (o_out.rot_y),
        .o_rot_z (o_out.rot_z),
        .o_sat   (o_out.saturated)
    );

    // a stalled pipeline keeps its in-flight beats
    a_cor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en && cor_vld |=> cor_vld)
        else $error("cordic beat lost during stall");

    a_mat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(mat_vld))
        else $error("matrix stage moved during stall");

    // a clipped result sits at a range limit in some component
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.saturated |->
            (o_out.rot_x == {1'b0, {(COORD_W-1){1'b1}}}) ||
            (o_out.rot_x == {1'b1, {(COORD_W-1){1'b0}}}) ||
            (o_out.rot_y == {1'b0, {(COORD_W-1){1'b1}}}) ||
            (o_out.rot_y == {1'b1, {(COORD_W-1){1'b0}}}) ||
            (o_out.rot_z == {1'b0, {(COORD_W-1){1'b1}}}) ||
            (o_out.rot_z == {1'b1, {(COORD_W-1){1'b0}}}))
        else $error("saturated flag without clipped component");

endmodule
